[rtl/assert_macros.svh]
// assert_macros.svh: assertion macros for the DNS record header parser.
// Depends on nothing; included by the top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/dnsrp_pkg.sv]
// dnsrp_pkg: types, codes and helpers of the DNS record header parser.
// Used by every module of the block; depends on nothing.
package dnsrp_pkg;

  typedef enum logic [2:0] {
    PH_NAME,
    PH_TYPE,
    PH_CLASS,
    PH_TTL,
    PH_RDLEN,
    PH_RDATA,
    PH_WAIT
  } phase_t;

  localparam logic [1:0] K_LABEL = 2'd0;
  localparam logic [1:0] K_RDATA = 2'd1;
  localparam logic [1:0] K_DONE  = 2'd2;
  localparam logic [1:0] K_ERR   = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FORMAT   = 2'd1;
  localparam logic [1:0] ST_COMPRESS = 2'd2;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  // packed so that label_offset lands in the low bits
  typedef struct packed {
    logic [15:0] rdata_length;
    logic [31:0] ttl;
    logic [15:0] record_class;
    logic [15:0] record_type;
    logic [7:0]  name_length;
    logic [7:0]  label_count;
    logic [1:0]  status;
    logic [7:0]  out_byte;
    logic [7:0]  label_offset;
  } payload_t;

  localparam int PAYLOAD_W = $bits(payload_t);
  localparam int TDATA_W   = ((PAYLOAD_W + 7) / 8) * 8;

  typedef struct packed {
    logic [1:0] kind;
    logic       last;
    payload_t   pl;
  } result_t;

  // one queue entry: optional rdata byte ahead of the main result
  typedef struct packed {
    logic    pre;
    logic [7:0] rbyte;
    result_t res;
  } qent_t;

  typedef struct packed {
    logic  valid;
    qent_t ent;
  } qpush_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  function automatic logic valid_char(input logic [7:0] b);
    valid_char = (b == 8'h2d) || (b == 8'h5f) ||
                 (b >= 8'h30 && b <= 8'h39) ||
                 (b >= 8'h61 && b <= 8'h7a) ||
                 (b >= 8'h41 && b <= 8'h5a);
  endfunction

endpackage

[rtl/dnsrp_front.sv]
// dnsrp_front: accepts message bytes, runs the record parse state machine
// and pushes result requests into the queue. Depends on dnsrp_pkg.
module dnsrp_front
  import dnsrp_pkg::*;
#(
  parameter int NAME_MAX = 256
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic       cfg_wdata,
  input  logic       accept,
  input  logic [7:0] data_byte,
  input  logic       restart,
  output qpush_t     push
);

  localparam logic [8:0] NameLimit = 9'(NAME_MAX - 1);

  logic        record_kind;
  phase_t      phase, phase_next;
  logic [1:0]  fbc, fbc_next;
  logic [7:0]  label_left, label_left_next;
  logic [7:0]  nbs, nbs_next;
  logic [7:0]  nlab, nlab_next;
  logic [15:0] type_shift, type_shift_next;
  logic [15:0] class_shift, class_shift_next;
  logic [31:0] ttl_shift, ttl_shift_next;
  logic [15:0] rdlen_shift, rdlen_shift_next;
  logic [15:0] rdata_left, rdata_left_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      record_kind <= 1'b0;
    end else if (cfg_we) begin
      record_kind <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_NAME;
      fbc        <= '0;
      label_left <= '0;
      nbs        <= '0;
      nlab       <= '0;
      rdata_left <= '0;
    end else begin
      phase      <= phase_next;
      fbc        <= fbc_next;
      label_left <= label_left_next;
      nbs        <= nbs_next;
      nlab       <= nlab_next;
      rdata_left <= rdata_left_next;
    end
  end

  // field shifters fill completely before use
  always_ff @(posedge clk) begin
    type_shift  <= type_shift_next;
    class_shift <= class_shift_next;
    ttl_shift   <= ttl_shift_next;
    rdlen_shift <= rdlen_shift_next;
  end

  always_comb begin
    phase_t      ph;
    logic [1:0]  fb;
    logic [7:0]  ll, nb, nl;
    logic [8:0]  count;
    logic [15:0] cls_new, rdl_new, left_dec;
    result_t     res;

    ph = phase;
    fb = fbc;
    ll = label_left;
    nb = nbs;
    nl = nlab;
    if (restart) begin
      ph = PH_NAME;
      fb = '0;
      ll = '0;
      nb = '0;
      nl = '0;
    end
    count    = {1'b0, nb} + 9'd1;
    cls_new  = {class_shift[7:0], data_byte};
    rdl_new  = {rdlen_shift[7:0], data_byte};
    left_dec = rdata_left - 16'd1;

    phase_next       = phase;
    fbc_next         = fbc;
    label_left_next  = label_left;
    nbs_next         = nbs;
    nlab_next        = nlab;
    type_shift_next  = type_shift;
    class_shift_next = class_shift;
    ttl_shift_next   = ttl_shift;
    rdlen_shift_next = rdlen_shift;
    rdata_left_next  = rdata_left;
    push             = '0;
    res              = '0;
    res.last         = 1'b1;

    if (accept) begin
      phase_next      = ph;
      fbc_next        = fb;
      label_left_next = ll;
      nbs_next        = nb;
      nlab_next       = nl;

      unique case (ph)
        PH_NAME: begin
          if (data_byte == 8'd0) begin
            nbs_next   = count[7:0];
            phase_next = PH_TYPE;
            fbc_next   = '0;
          end else if (count >= NameLimit) begin
            res.kind           = K_ERR;
            res.pl.status      = ST_FORMAT;
            res.pl.label_count = nl;
            res.pl.name_length = count[7:0];
            push.valid         = 1'b1;
            phase_next         = PH_WAIT;
          end else if (ll == 8'd0) begin
            if (data_byte[7:6] == 2'b11) begin
              res.kind           = K_ERR;
              res.pl.status      = ST_COMPRESS;
              res.pl.label_count = nl;
              res.pl.name_length = count[7:0];
              push.valid         = 1'b1;
              phase_next         = PH_WAIT;
            end else begin
              label_left_next     = data_byte;
              nlab_next           = nl + 8'd1;
              nbs_next            = count[7:0];
              res.kind            = K_LABEL;
              res.pl.label_offset = nb;
              res.pl.label_count  = nl + 8'd1;
              push.valid          = 1'b1;
            end
          end else if (!valid_char(data_byte)) begin
            res.kind           = K_ERR;
            res.pl.status      = ST_FORMAT;
            res.pl.label_count = nl;
            res.pl.name_length = count[7:0];
            push.valid         = 1'b1;
            phase_next         = PH_WAIT;
          end else begin
            label_left_next = ll - 8'd1;
            nbs_next        = count[7:0];
          end
        end
        PH_TYPE: begin
          type_shift_next = {type_shift[7:0], data_byte};
          if (fb == 2'd1) begin
            fbc_next   = '0;
            phase_next = PH_CLASS;
          end else begin
            fbc_next = fb + 2'd1;
          end
        end
        PH_CLASS: begin
          class_shift_next = cls_new;
          if (fb == 2'd1) begin
            fbc_next = '0;
            if (!record_kind) begin
              res.kind            = K_DONE;
              res.pl.label_count  = nl;
              res.pl.name_length  = nb;
              res.pl.record_type  = type_shift;
              res.pl.record_class = cls_new;
              push.valid          = 1'b1;
              phase_next          = PH_NAME;
              label_left_next     = '0;
              nbs_next            = '0;
              nlab_next           = '0;
            end else begin
              phase_next = PH_TTL;
            end
          end else begin
            fbc_next = fb + 2'd1;
          end
        end
        PH_TTL: begin
          ttl_shift_next = {ttl_shift[23:0], data_byte};
          if (fb == 2'd3) begin
            fbc_next   = '0;
            phase_next = PH_RDLEN;
          end else begin
            fbc_next = fb + 2'd1;
          end
        end
        PH_RDLEN: begin
          rdlen_shift_next = rdl_new;
          if (fb == 2'd1) begin
            fbc_next = '0;
            if (rdl_new == 16'd0) begin
              res.kind            = K_DONE;
              res.pl.label_count  = nl;
              res.pl.name_length  = nb;
              res.pl.record_type  = type_shift;
              res.pl.record_class = class_shift;
              res.pl.ttl          = ttl_shift;
              res.pl.rdata_length = rdl_new;
              push.valid          = 1'b1;
              phase_next          = PH_NAME;
              label_left_next     = '0;
              nbs_next            = '0;
              nlab_next           = '0;
            end else begin
              rdata_left_next = rdl_new;
              phase_next      = PH_RDATA;
            end
          end else begin
            fbc_next = fb + 2'd1;
          end
        end
        PH_RDATA: begin
          rdata_left_next = left_dec;
          push.valid      = 1'b1;
          if (left_dec == 16'd0) begin
            push.ent.pre        = 1'b1;
            push.ent.rbyte      = data_byte;
            res.kind            = K_DONE;
            res.pl.label_count  = nl;
            res.pl.name_length  = nb;
            res.pl.record_type  = type_shift;
            res.pl.record_class = class_shift;
            res.pl.ttl          = ttl_shift;
            res.pl.rdata_length = rdlen_shift;
            phase_next          = PH_NAME;
            label_left_next     = '0;
            nbs_next            = '0;
            nlab_next           = '0;
          end else begin
            res.kind        = K_RDATA;
            res.pl.out_byte = data_byte;
          end
        end
        default: begin
        end
      endcase
    end
    push.ent.res = res;
  end

endmodule

[rtl/dnsrp_queue.sv]
// dnsrp_queue: short request queue between the parse front and the
// result back end. Depends on dnsrp_pkg.
module dnsrp_queue
  import dnsrp_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  qpush_t push,
  input  logic   pop,
  output qent_t  head,
  output qstat_t stat
);

  qent_t             mem [QDEPTH];
  logic [QPTR_W-1:0] wptr, rptr;
  logic [QPTR_W:0]   count;
  logic              do_pop;

  assign do_pop     = pop && (count != '0);
  assign head       = mem[rptr];
  assign stat.full  = (count == (QPTR_W + 1)'(QDEPTH));
  assign stat.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (push.valid) begin
      mem[wptr] <= push.ent;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push.valid) begin
        wptr <= wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= rptr + 1'b1;
      end
      count <= count + (QPTR_W + 1)'(push.valid) - (QPTR_W + 1)'(do_pop);
    end
  end

endmodule

[rtl/dnsrp_back.sv]
// dnsrp_back: drains queued requests into the registered result stream,
// splitting a final rdata byte and its summary into two results.
// Depends on dnsrp_pkg.
module dnsrp_back
  import dnsrp_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  qent_t   head,
  input  qstat_t  stat,
  output logic    pop,
  input  logic    out_ready,
  output logic    out_valid,
  output result_t out_res
);

  logic    sent, sent_next;
  logic    valid_next;
  result_t res_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      sent      <= 1'b0;
    end else begin
      out_valid <= valid_next;
      sent      <= sent_next;
    end
  end

  always_ff @(posedge clk) begin
    out_res <= res_next;
  end

  always_comb begin
    pop        = 1'b0;
    valid_next = out_valid;
    sent_next  = sent;
    res_next   = out_res;
    if (!out_valid || out_ready) begin
      if (!stat.empty) begin
        valid_next = 1'b1;
        if (head.pre && !sent) begin
          res_next          = '0;
          res_next.kind     = K_RDATA;
          res_next.last     = 1'b0;
          res_next.pl.out_byte = head.rbyte;
          sent_next         = 1'b1;
        end else begin
          res_next  = head.res;
          pop       = 1'b1;
          sent_next = 1'b0;
        end
      end else begin
        valid_next = 1'b0;
      end
    end
  end

endmodule

[rtl/dns_record_header_parser_top.sv]
// DNS record header parser, top level.
// Message bytes enter on s_tdata with s_tuser as the restart flag; results
// leave on m_tdata/m_tuser/m_tlast. Config: cfg_we/cfg_wdata set record_kind
// (0 question entries, 1 full resource records), sampled at the class end.
// Throughput: one byte per cycle while the queue is not full. A byte
// that yields a result passes the queue and then the output register.
// The last rdata byte yields two results (rdata byte, then record done)
// from one queue entry; the 4-entry queue between the parser and the
// output register absorbs that and any receiver stall.
// s_tready drops only when the queue is full; a stalled receiver holds the
// current result stable until m_tready.
// Reset (rst, synchronous) clears the queue, the output valid, the parse
// state (name start) and record_kind to 0.
// After a format or compression error, bytes are consumed silently until
// one arrives with restart set.
// Depends on dnsrp_pkg, assert_macros.svh, dnsrp_front, dnsrp_queue, dnsrp_back.
`include "assert_macros.svh"

module dns_record_header_parser_top
  import dnsrp_pkg::*;
#(
  parameter int NAME_MAX = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic               cfg_wdata,    // record_kind
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [7:0]         s_tdata,      // data_byte
  input  logic               s_tuser,      // restart
  output logic               m_tvalid,
  input  logic               m_tready,
  // m_tdata, low bit up: label_offset, out_byte, status, label_count,
  // name_length, record_type, record_class, ttl, rdata_length, zero fill
  output logic [TDATA_W-1:0] m_tdata,
  output logic [1:0]         m_tuser,      // kind
  output logic               m_tlast       // last
);

  qpush_t  push;
  qent_t   head;
  qstat_t  stat;
  logic    pop;
  logic    accept;
  result_t out_res;

  assign s_tready = !stat.full;
  assign accept   = s_tvalid && s_tready;

  dnsrp_front #(
    .NAME_MAX(NAME_MAX)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .accept    (accept),
    .data_byte (s_tdata),
    .restart   (s_tuser),
    .push      (push)
  );

  dnsrp_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .pop  (pop),
    .head (head),
    .stat (stat)
  );

  dnsrp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .stat      (stat),
    .pop       (pop),
    .out_ready (m_tready),
    .out_valid (m_tvalid),
    .out_res   (out_res)
  );

  assign m_tdata = TDATA_W'(out_res.pl);
  assign m_tuser = out_res.kind;
  assign m_tlast = out_res.last;

  `ASSERT_NOW(a_no_overflow, clk, rst, push.valid, !stat.full, "queue push while full")
  `ASSERT_NOW(a_status_err, clk, rst, m_tvalid && (m_tuser != K_ERR),
              out_res.pl.status == ST_OK, "nonzero status on a non-error result")
  `ASSERT_NOW(a_notlast_rdata, clk, rst, m_tvalid && !m_tlast, m_tuser == K_RDATA,
              "non-last result that is not an rdata byte")
  `ASSERT_NEXT(a_push_needs_accept, clk, rst, !accept, !push.valid || accept,
               "request pushed without an accepted byte")

endmodule
